FILE: design/spc_pkg.sv
`default_nettype none
package spc_pkg;

  localparam int SCREEN_COLUMNS_DEF = 128;
  localparam logic [15:0] CENTRE_COL = 16'd64;

  typedef struct packed {
    logic [31:0] tx_left;
    logic [31:0] tx_right;
    logic [31:0] x_scale;
    logic [31:0] x_inv_scale;
    logic [31:0] top_z;
    logic [9:0]  patch_width;
  } s1_t;

  typedef struct packed {
    logic [15:0] prod_left_hi;
    logic [15:0] prod_right_hi;
    logic [31:0] x_inv_scale;
    logic [31:0] top_z;
    logic [9:0]  patch_width;
  } s2_t;

  typedef struct packed {
    logic        visible;
    logic [7:0]  left_col;
    logic [6:0]  right_col;
    logic        neg_left;
    logic [15:0] x1;
    logic [31:0] x_inv_scale;
    logic [31:0] top_z;
    logic [9:0]  patch_width;
  } s3_t;

  typedef struct packed {
    logic        visible;
    logic [7:0]  left_col;
    logic [6:0]  right_col;
    logic        neg_left;
    logic [31:0] frac_prod;
    logic [31:0] frac_base;
    logic [31:0] top_z;
  } s4_t;

  typedef struct packed {
    logic        visible;
    logic [7:0]  left_col;
    logic [6:0]  right_col;
    logic [31:0] top_z;
    logic [31:0] texture_mid;
    logic [31:0] start_frac;
  } res_t;

endpackage
`default_nettype wire

FILE: design/spc_in_if.sv
`default_nettype none
interface spc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sprite_x;
  logic signed [31:0] x_scale;
  logic signed [31:0] x_inv_scale;
  logic signed [31:0] bottom_z;
  logic signed [15:0] left_offset;
  logic [9:0]         patch_width;
  logic [9:0]         patch_height;

  modport source (output valid, sprite_x, x_scale, x_inv_scale, bottom_z, left_offset,
                  patch_width, patch_height, input ready);
  modport sink (input valid, sprite_x, x_scale, x_inv_scale, bottom_z, left_offset,
                patch_width, patch_height, output ready);
endinterface
`default_nettype wire

FILE: design/spc_out_if.sv
`default_nettype none
interface spc_out_if;
  logic               valid;
  logic               ready;
  logic               visible;
  logic [7:0]         left_col;
  logic [6:0]         right_col;
  logic signed [31:0] top_z;
  logic signed [31:0] texture_mid;
  logic signed [31:0] start_frac;

  modport source (output valid, visible, left_col, right_col, top_z, texture_mid,
                  start_frac, input ready);
  modport sink (input valid, visible, left_col, right_col, top_z, texture_mid,
                start_frac, output ready);
endinterface
`default_nettype wire

FILE: design/spc_cfg_if.sv
`default_nettype none
interface spc_cfg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] view_z;

  modport source (output valid, view_z, input ready);
  modport sink (input valid, view_z, output ready);
endinterface
`default_nettype wire

FILE: design/sprite_projection_clip.sv
// Sprite projection and clipping.
// in_chan carries one sprite per item: view-space x, x scale, inverse
// scale, base height and the patch's left offset, width and height.
// out_chan returns exactly one item per sprite, in order: visible, the
// clamped left and right screen columns, top height, texture mid and the
// starting texture fraction. Rejected sprites come out with visible low
// and all other fields zero.
// cfg_chan writes the viewer height; it is always ready and should be
// written only while no sprite is in flight.
// One item per cycle is accepted while out_chan is not stalled. The five
// pipeline stages are edge setup, the two 32x32 projection multiplies,
// column clip, the texture-step multiply and the result register.
// Reset (rst_n low, synchronous) empties the pipeline and clears the
// viewer height to zero. When out_chan stalls with a result waiting, every
// stage holds, bubbles included, and in_chan.ready drops; nothing is lost.
`default_nettype none
module sprite_projection_clip #(
  parameter int SCREEN_COLUMNS = spc_pkg::SCREEN_COLUMNS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  spc_in_if.sink    in_chan,
  spc_out_if.source out_chan,
  spc_cfg_if.sink   cfg_chan
);

  logic           en;
  logic [31:0]    view_z_r;
  logic           s3_valid;
  spc_pkg::s3_t   s3;
  logic           res_valid;
  spc_pkg::res_t  res;

  assign en             = !res_valid || out_chan.ready;
  assign in_chan.ready  = en;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_z_r <= 32'd0;
    end else if (cfg_chan.valid) begin
      view_z_r <= cfg_chan.view_z;
    end
  end

  spc_project #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS)
  ) u_project (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_chan.valid),
    .sprite_x    (in_chan.sprite_x),
    .x_scale     (in_chan.x_scale),
    .x_inv_scale (in_chan.x_inv_scale),
    .bottom_z    (in_chan.bottom_z),
    .left_offset (in_chan.left_offset),
    .patch_width (in_chan.patch_width),
    .patch_height(in_chan.patch_height),
    .s3_valid    (s3_valid),
    .s3          (s3)
  );

  spc_frac u_frac (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .s3_valid (s3_valid),
    .s3       (s3),
    .view_z   (view_z_r),
    .res_valid(res_valid),
    .res      (res)
  );

  assign out_chan.valid       = res_valid;
  assign out_chan.visible     = res.visible;
  assign out_chan.left_col    = res.left_col;
  assign out_chan.right_col   = res.right_col;
  assign out_chan.top_z       = res.top_z;
  assign out_chan.texture_mid = res.texture_mid;
  assign out_chan.start_frac  = res.start_frac;

endmodule
`default_nettype wire

FILE: design/spc_project.sv
`default_nettype none
module spc_project #(
  parameter int SCREEN_COLUMNS = spc_pkg::SCREEN_COLUMNS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [31:0]        sprite_x,
  input  wire logic [31:0]        x_scale,
  input  wire logic [31:0]        x_inv_scale,
  input  wire logic [31:0]        bottom_z,
  input  wire logic [15:0]        left_offset,
  input  wire logic [9:0]         patch_width,
  input  wire logic [9:0]         patch_height,
  output logic                    s3_valid,
  output spc_pkg::s3_t            s3
);

  localparam logic signed [16:0] SC_S   = 17'(SCREEN_COLUMNS);
  localparam logic [6:0]         RC_MAX = 7'(SCREEN_COLUMNS - 1);

  logic          v1_r, v2_r, v3_r;
  spc_pkg::s1_t  s1_nxt, s1_r;
  spc_pkg::s2_t  s2_nxt, s2_r;
  spc_pkg::s3_t  s3_nxt, s3_r;

  // stage 1: edge positions and top height
  always_comb begin
    s1_nxt.tx_left     = sprite_x - {left_offset, 16'h0000};
    s1_nxt.tx_right    = sprite_x - {left_offset, 16'h0000} + {6'd0, patch_width, 16'h0000};
    s1_nxt.x_scale     = x_scale;
    s1_nxt.x_inv_scale = x_inv_scale;
    s1_nxt.top_z       = bottom_z + {6'd0, patch_height, 16'h0000};
    s1_nxt.patch_width = patch_width;
  end

  // stage 2: 16.16 products, only the integer half is needed
  always_comb begin
    logic signed [63:0] p_left;
    logic signed [63:0] p_right;
    p_left  = $signed(s1_r.tx_left) * $signed(s1_r.x_scale);
    p_right = $signed(s1_r.tx_right) * $signed(s1_r.x_scale);
    s2_nxt.prod_left_hi  = p_left[47:32];
    s2_nxt.prod_right_hi = p_right[47:32];
    s2_nxt.x_inv_scale   = s1_r.x_inv_scale;
    s2_nxt.top_z         = s1_r.top_z;
    s2_nxt.patch_width   = s1_r.patch_width;
  end

  // stage 3: columns, reject and clamp
  always_comb begin
    logic [15:0]        x1;
    logic [15:0]        x2;
    logic signed [16:0] x1_s;
    logic signed [16:0] x2_s;
    logic               reject;
    x1     = s2_r.prod_left_hi + spc_pkg::CENTRE_COL;
    x2     = s2_r.prod_right_hi + spc_pkg::CENTRE_COL;
    x1_s   = {x1[15], x1};
    x2_s   = {x2[15], x2};
    reject = (x1_s > SC_S) || x2[15];
    s3_nxt.visible     = !reject;
    s3_nxt.left_col    = (reject || x1[15]) ? 8'd0 : x1[7:0];
    s3_nxt.right_col   = reject ? 7'd0 : ((x2_s >= SC_S) ? RC_MAX : x2[6:0]);
    s3_nxt.neg_left    = x1[15];
    s3_nxt.x1          = x1;
    s3_nxt.x_inv_scale = s2_r.x_inv_scale;
    s3_nxt.top_z       = s2_r.top_z;
    s3_nxt.patch_width = s2_r.patch_width;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign s3_valid = v3_r;
  assign s3       = s3_r;

endmodule
`default_nettype wire

FILE: design/spc_frac.sv
`default_nettype none
module spc_frac (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          s3_valid,
  input  wire spc_pkg::s3_t  s3,
  input  wire logic [31:0]   view_z,
  output logic               res_valid,
  output spc_pkg::res_t      res
);

  logic           v4_r, v5_r;
  spc_pkg::s4_t   s4_nxt, s4_r;
  spc_pkg::res_t  res_nxt, res_r;

  // stage 4: texture step times left column, low word only
  always_comb begin
    logic [31:0] prod;
    prod = s3.x_inv_scale * {{16{s3.x1[15]}}, s3.x1};
    s4_nxt.visible   = s3.visible;
    s4_nxt.left_col  = s3.left_col;
    s4_nxt.right_col = s3.right_col;
    s4_nxt.neg_left  = s3.neg_left;
    s4_nxt.frac_prod = prod;
    s4_nxt.frac_base = s3.x_inv_scale[31] ? ({6'd0, s3.patch_width, 16'h0000} - 32'd1)
                                          : 32'd0;
    s4_nxt.top_z     = s3.top_z;
  end

  // stage 5: result register
  always_comb begin
    logic [31:0] frac;
    frac = s4_r.neg_left ? (s4_r.frac_base - s4_r.frac_prod) : s4_r.frac_base;
    res_nxt.visible     = s4_r.visible;
    res_nxt.left_col    = s4_r.left_col;
    res_nxt.right_col   = s4_r.right_col;
    res_nxt.top_z       = s4_r.visible ? s4_r.top_z : 32'd0;
    res_nxt.texture_mid = s4_r.visible ? (s4_r.top_z - view_z) : 32'd0;
    res_nxt.start_frac  = s4_r.visible ? frac : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= s3_valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_r  <= s4_nxt;
      res_r <= res_nxt;
    end
  end

  assign res_valid = v5_r;
  assign res       = res_r;

endmodule
`default_nettype wire
